// File: hdl/restoring_divider_core_defines.svh
// ----------------------------------------------------------------------------
// Restoring divider core - assertion macros
// Property shorthands for the divider port checker.
// ----------------------------------------------------------------------------
`ifndef RESTORING_DIVIDER_CORE_DEFINES_SVH
`define RESTORING_DIVIDER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> cons) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> cons) \
    else $error(msg);

`endif

// File: hdl/rdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider package
// Control word that travels alongside the data through every pipeline stage.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Per-stage control: word present, quotient must be negated, divisor zero.
  typedef struct packed {
    logic valid;
    logic neg;
    logic dz;
  } ctrl_t;

endpackage

// File: hdl/rdc_prep.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider - operand stage
// Registers operand magnitudes, quotient sign and the zero-divisor flag.
// ----------------------------------------------------------------------------
module rdc_prep #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  logic signed [WIDTH-1:0] dividend_i,
  input  logic signed [WIDTH-1:0] divisor_i,
  output rdc_pkg::ctrl_t          ctrl_o,
  output logic [WIDTH-2:0]        part_o,
  output logic [WIDTH-1:0]        aq_o,
  output logic [WIDTH-1:0]        dvsr_o
);
  import rdc_pkg::*;

  ctrl_t            ctrl_d, ctrl_q;
  logic [WIDTH-1:0] mag_a_d, mag_d_d;
  logic [WIDTH-1:0] aq_q, dvsr_q;

  // Negating the most negative value yields 2^(WIDTH-1), which fits unsigned.
  always_comb begin
    mag_a_d      = dividend_i[WIDTH-1] ? (~dividend_i + 1'b1) : dividend_i;
    mag_d_d      = divisor_i[WIDTH-1]  ? (~divisor_i + 1'b1)  : divisor_i;
    ctrl_d.valid = accept_i;
    ctrl_d.neg   = dividend_i[WIDTH-1] ^ divisor_i[WIDTH-1];
    ctrl_d.dz    = (divisor_i == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    aq_q   <= mag_a_d;
    dvsr_q <= mag_d_d;
  end

  assign ctrl_o = ctrl_q;
  assign part_o = '0;
  assign aq_o   = aq_q;
  assign dvsr_o = dvsr_q;

endmodule

// File: hdl/rdc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider - division cell
// One restoring step: shift in a dividend bit, trial-subtract, keep or restore.
// ----------------------------------------------------------------------------
module rdc_cell #(
  parameter int WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rdc_pkg::ctrl_t   ctrl_i,
  input  logic [WIDTH-2:0] part_i,
  input  logic [WIDTH-1:0] aq_i,
  input  logic [WIDTH-1:0] dvsr_i,
  output rdc_pkg::ctrl_t   ctrl_o,
  output logic [WIDTH-2:0] part_o,
  output logic [WIDTH-1:0] aq_o,
  output logic [WIDTH-1:0] dvsr_o
);
  import rdc_pkg::*;

  ctrl_t            ctrl_q;
  logic [WIDTH-1:0] shifted;
  logic [WIDTH:0]   diff;
  logic             ge;
  logic [WIDTH-2:0] part_d, part_q;
  logic [WIDTH-1:0] aq_d, aq_q, dvsr_q;

  // aq holds the unconsumed dividend bits on top and quotient bits below.
  always_comb begin
    shifted = {part_i, aq_i[WIDTH-1]};
    diff    = {1'b0, shifted} - {1'b0, dvsr_i};
    ge      = ~diff[WIDTH];
    // Partial remainder stays below the divisor, so its top bit is dropped.
    part_d  = ge ? diff[WIDTH-2:0] : shifted[WIDTH-2:0];
    aq_d    = {aq_i[WIDTH-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else begin
      ctrl_q <= ctrl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    part_q <= part_d;
    aq_q   <= aq_d;
    dvsr_q <= dvsr_i;
  end

  assign ctrl_o = ctrl_q;
  assign part_o = part_q;
  assign aq_o   = aq_q;
  assign dvsr_o = dvsr_q;

endmodule

// File: hdl/rdc_post.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider - result stage
// Applies the quotient sign, saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
module rdc_post #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rdc_pkg::ctrl_t          ctrl_i,
  input  logic [WIDTH-2:0]        part_i,
  input  logic [WIDTH-1:0]        quo_i,
  output logic                    valid_o,
  output logic signed [WIDTH-1:0] quotient_o,
  output logic [WIDTH-2:0]        remainder_o,
  output logic                    status_o
);
  import rdc_pkg::*;

  logic                    valid_q;
  logic signed [WIDTH-1:0] quot_d, quot_q;
  logic [WIDTH-2:0]        rem_d, rem_q;
  logic                    status_d, status_q;

  always_comb begin
    status_d = ctrl_i.dz;
    if (ctrl_i.dz) begin
      quot_d = '0;
      rem_d  = '0;
    end else begin
      rem_d = part_i;
      if (ctrl_i.neg) begin
        quot_d = ~quo_i + 1'b1;
      end else if (quo_i[WIDTH-1]) begin
        // Only the most negative value over minus one gets here: saturate.
        quot_d = {1'b0, {(WIDTH-1){1'b1}}};
      end else begin
        quot_d = quo_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q   <= quot_d;
    rem_q    <= rem_d;
    status_q <= status_d;
  end

  assign valid_o     = valid_q;
  assign quotient_o  = quot_q;
  assign remainder_o = rem_q;
  assign status_o    = status_q;

endmodule

// File: hdl/restoring_divider_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider core
// Signed WIDTH-bit division by a pipelined row of restoring cells.
// ----------------------------------------------------------------------------
//
//  channel   handshake          payload
//  -------   ----------------   -------------------------------------------
//  operand   start / busy       dividend_i, divisor_i
//  result    valid_o (strobe)   quotient_o, remainder_o, status_o
//
//  Throughput: one word per cycle unless busy; each cell handles one
//  quotient bit, and new pairs enter the operand stage as older ones advance.
//  Pipeline: WIDTH + 2 register stages (operand stage, WIDTH cells, result
//  stage). The strobe and the result are registered together in the result
//  stage, so the result is valid while the strobe is high.
//  Reset: asynchronous, active low; drops every word in flight. busy is high
//  during reset and until the first edge after release, low from then on.
//  Stalls: none; the result side takes every word in the cycle it shows.
// ----------------------------------------------------------------------------
module restoring_divider_core #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [WIDTH-1:0] dividend_i,
  input  logic signed [WIDTH-1:0] divisor_i,
  output logic                    valid_o,
  output logic signed [WIDTH-1:0] quotient_o,
  output logic [WIDTH-2:0]        remainder_o,
  output logic                    status_o
);
  import rdc_pkg::*;

  // Stage k holds the word after k restoring steps.
  ctrl_t            ctrl_s [WIDTH+1];
  logic [WIDTH-2:0] part_s [WIDTH+1];
  logic [WIDTH-1:0] aq_s   [WIDTH+1];
  logic [WIDTH-1:0] dvsr_s [WIDTH+1];

  logic busy_q;

  // Hold off new words until the first edge after reset release.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= 1'b0;
    end
  end

  assign busy = busy_q;

  // Take magnitudes and register them with the sign and zero flags.
  rdc_prep #(.WIDTH(WIDTH)) u_prep (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (start & ~busy_q),
    .dividend_i (dividend_i),
    .divisor_i  (divisor_i),
    .ctrl_o     (ctrl_s[0]),
    .part_o     (part_s[0]),
    .aq_o       (aq_s[0]),
    .dvsr_o     (dvsr_s[0])
  );

  // Row of cells: each one consumes the top dividend bit and shifts in a
  // quotient bit, so after WIDTH cells aq holds the full unsigned quotient.
  for (genvar k = 0; k < WIDTH; k++) begin : g_cell
    rdc_cell #(.WIDTH(WIDTH)) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_s[k]),
      .part_i (part_s[k]),
      .aq_i   (aq_s[k]),
      .dvsr_i (dvsr_s[k]),
      .ctrl_o (ctrl_s[k+1]),
      .part_o (part_s[k+1]),
      .aq_o   (aq_s[k+1]),
      .dvsr_o (dvsr_s[k+1])
    );
  end

  // Fix the sign, saturate the single overflow case, flag a zero divisor.
  rdc_post #(.WIDTH(WIDTH)) u_post (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl_s[WIDTH]),
    .part_i      (part_s[WIDTH]),
    .quo_i       (aq_s[WIDTH]),
    .valid_o     (valid_o),
    .quotient_o  (quotient_o),
    .remainder_o (remainder_o),
    .status_o    (status_o)
  );

endmodule

// File: hdl/rdc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider - port checker
// Checks latency and status behavior as seen on the core's ports.
// ----------------------------------------------------------------------------
`include "restoring_divider_core_defines.svh"

module rdc_checker #(
  parameter int WIDTH = 32
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    start,
  input logic                    busy,
  input logic signed [WIDTH-1:0] dividend_i,
  input logic signed [WIDTH-1:0] divisor_i,
  input logic                    valid_o,
  input logic signed [WIDTH-1:0] quotient_o,
  input logic [WIDTH-2:0]        remainder_o,
  input logic                    status_o
);

  localparam int LAT = WIDTH + 2;

  `RDC_ASSERT_IMPL(a_fixed_latency, clk_i, rst_ni, start && !busy, ##LAT valid_o, "accepted word did not produce a result after the pipeline latency")
  `RDC_ASSERT_IMPL(a_no_phantom, clk_i, rst_ni, valid_o, $past(start && !busy, LAT), "result strobe without a matching accepted word")
  `RDC_ASSERT_IMPL(a_status_match, clk_i, rst_ni, valid_o, (status_o == ($past(divisor_i, LAT) == '0)), "status does not match a zero divisor")
  `RDC_ASSERT_IMPL(a_dz_zero, clk_i, rst_ni, valid_o && status_o, (quotient_o == '0) && (remainder_o == '0), "divide by zero result not cleared")

endmodule

bind restoring_divider_core rdc_checker #(.WIDTH(WIDTH)) u_rdc_checker (.*);

// File: bench/rdc_div_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider checker
// Watches the operand and result channels of the divider, predicts every
// quotient, remainder and status, and counts mismatches for the bench top.
// ----------------------------------------------------------------------------
module rdc_div_checker #(
  parameter int WIDTH = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    busy_i,
  input  logic signed [WIDTH-1:0] dividend_i,
  input  logic signed [WIDTH-1:0] divisor_i,
  input  logic                    valid_i,
  input  logic signed [WIDTH-1:0] quotient_i,
  input  logic [WIDTH-2:0]        remainder_i,
  input  logic                    status_i,
  output int                      errors_o,
  output int                      pending_o,
  output int                      checked_o
);

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_DIV_ZERO = 1'b1;
  localparam int   REPORT_LIMIT    = 10;

  typedef struct packed {
    logic signed [WIDTH-1:0] quotient;
    logic [WIDTH-2:0]        remainder;
    logic                    status;
  } div_result_t;

  div_result_t quotient_fifo[$];

  // Divide magnitudes bit by bit, MSB first, restoring on a negative trial.
  function automatic div_result_t predict_division(input logic [WIDTH-1:0] num,
                                                   input logic [WIDTH-1:0] den);
    logic [WIDTH-1:0] num_mag;
    logic [WIDTH-1:0] den_mag;
    logic [WIDTH-1:0] quo;
    logic [WIDTH:0]   part;
    logic             flip;
    div_result_t      res;
    num_mag = num[WIDTH-1] ? -num : num;
    den_mag = den[WIDTH-1] ? -den : den;
    flip    = num[WIDTH-1] ^ den[WIDTH-1];
    res     = '0;
    if (den_mag == '0) begin
      res.status = STATUS_DIV_ZERO;
      return res;
    end
    part = '0;
    quo  = '0;
    for (int i = WIDTH - 1; i >= 0; i--) begin
      part = {part[WIDTH-1:0], num_mag[i]};
      quo  = {quo[WIDTH-2:0], 1'b0};
      if (part >= {1'b0, den_mag}) begin
        part   = part - {1'b0, den_mag};
        quo[0] = 1'b1;
      end
    end
    // Only the most negative dividend over -1 can overflow; clamp it.
    if (flip) begin
      quo = -quo;
    end else if (quo[WIDTH-1]) begin
      quo = {1'b0, {(WIDTH-1){1'b1}}};
    end
    res.quotient  = quo;
    res.remainder = part[WIDTH-2:0];
    res.status    = STATUS_OK;
    return res;
  endfunction

  // Sample mid-cycle, where both channels are settled.
  always @(negedge clk_i) begin
    div_result_t want;
    if (rst_ni) begin
      if (start_i && !busy_i) begin
        quotient_fifo.push_back(predict_division(dividend_i, divisor_i));
      end
      if (valid_i) begin
        if (quotient_fifo.size() == 0) begin
          errors_o <= errors_o + 1;
          if (errors_o < REPORT_LIMIT) begin
            $display("[%0t] unexpected result word q=%0d r=%0d s=%0b",
                     $realtime, quotient_i, remainder_i, status_i);
          end
        end else begin
          want = quotient_fifo.pop_front();
          checked_o <= checked_o + 1;
          if (want.quotient !== quotient_i || want.remainder !== remainder_i ||
              want.status !== status_i) begin
            errors_o <= errors_o + 1;
            if (errors_o < REPORT_LIMIT) begin
              $display("[%0t] mismatch: exp q=%0d r=%0d s=%0b, got q=%0d r=%0d s=%0b",
                       $realtime, want.quotient, want.remainder, want.status,
                       quotient_i, remainder_i, status_i);
            end
          end
        end
      end
    end
    pending_o <= quotient_fifo.size();
  end

  initial begin
    errors_o  = 0;
    pending_o = 0;
    checked_o = 0;
  end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Restoring divider bench top
// Drives directed corner operands and then random operand pairs into the
// divider with random gaps and gap-free bursts; the checker beside the block
// predicts each word and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WIDTH        = 32;
  localparam int RANDOM_WORDS = 1100;
  localparam int MAX_GAP      = 12;
  // Operand stage, one cell per quotient bit, result stage, plus margin.
  localparam int DRAIN_CYCLES = WIDTH + 8;

  localparam logic [WIDTH-1:0] MOST_NEG = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic [WIDTH-1:0] MOST_POS = {1'b0, {(WIDTH-1){1'b1}}};
  localparam logic [WIDTH-1:0] MINUS_ONE = '1;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start;
  logic                    busy;
  logic signed [WIDTH-1:0] dividend;
  logic signed [WIDTH-1:0] divisor;
  logic                    valid;
  logic signed [WIDTH-1:0] quotient;
  logic [WIDTH-2:0]        remainder;
  logic                    status;

  int errors;
  int pending;
  int checked;
  int sent_words;
  int zero_divisors;
  int overflow_words;

  restoring_divider_core #(
    .WIDTH(WIDTH)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .valid_o    (valid),
    .quotient_o (quotient),
    .remainder_o(remainder),
    .status_o   (status)
  );

  rdc_div_checker #(
    .WIDTH(WIDTH)
  ) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .busy_i     (busy),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .valid_i    (valid),
    .quotient_i (quotient),
    .remainder_i(remainder),
    .status_i   (status),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Present one operand word after an idle gap and hold it until the block
  // takes it. Leave start high on return so a zero gap keeps the stream
  // back to back without a low pulse inside one time step.
  task automatic issue_word(input logic [WIDTH-1:0] num, input logic [WIDTH-1:0] den,
                            input int gap);
    bit taken;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start    <= 1'b1;
    dividend <= num;
    divisor  <= den;
    taken = 1'b0;
    // Check busy mid-cycle; the word goes in at the edge that follows.
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    sent_words++;
    if (den == '0) begin
      zero_divisors++;
    end
    if (num == MOST_NEG && den == MINUS_ONE) begin
      overflow_words++;
    end
  endtask

  // Draw one operand from a mix of shapes: raw random words for bit
  // coverage, small and mid-size magnitudes of either sign so quotients
  // land in every range, powers of two, and the extremes.
  function automatic logic [WIDTH-1:0] draw_operand();
    logic [WIDTH-1:0] v;
    int shape;
    shape = $urandom_range(0, 9);
    case (shape)
      0, 1, 2, 3: begin
        v = $urandom;
      end
      4, 5: begin
        v = $urandom_range(0, 255);
      end
      6: begin
        case ($urandom_range(0, 4))
          0:       v = MOST_NEG;
          1:       v = MOST_POS;
          2:       v = MINUS_ONE;
          3:       v = 1;
          default: v = 0;
        endcase
        return v;
      end
      7: begin
        v = {{(WIDTH-1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH - 1);
      end
      default: begin
        v = $urandom >> $urandom_range(1, WIDTH - 2);
      end
    endcase
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  initial begin
    logic [WIDTH-1:0] num;
    logic [WIDTH-1:0] den;
    int               gap;
    int               drain;
    bit               burst;
    sent_words     = 0;
    zero_divisors  = 0;
    overflow_words = 0;
    rst_ni   <= 1'b0;
    start    <= 1'b0;
    dividend <= '0;
    divisor  <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners: divide by zero, the saturating overflow, the
    // extremes of both fields and every sign combination.
    issue_word('0, '0, 0);
    issue_word(5, '0, 1);
    issue_word(MOST_NEG, '0, 0);
    issue_word(MINUS_ONE, '0, 0);
    issue_word(MOST_NEG, MINUS_ONE, 0);
    issue_word(MOST_NEG, 1, 2);
    issue_word(MOST_NEG, MOST_NEG, 0);
    issue_word(MOST_POS, MOST_NEG, 0);
    issue_word(MOST_NEG, MOST_POS, 3);
    issue_word(MOST_POS, 1, 0);
    issue_word(MOST_POS, MINUS_ONE, 0);
    issue_word(MOST_POS, MOST_POS, 0);
    issue_word(MINUS_ONE, MOST_POS, 5);
    issue_word(MINUS_ONE, MINUS_ONE, 0);
    issue_word(7, 2, 0);
    issue_word(-7, 2, 0);
    issue_word(7, -2, 1);
    issue_word(-7, -2, 0);
    issue_word('0, 5, 0);
    issue_word(3, 7, 0);
    issue_word(-3, 7, 12);
    issue_word(1, MOST_POS, 0);
    issue_word(MOST_NEG, 2, 0);
    issue_word(MOST_NEG, -2, 0);

    // Random phase: switch between gap-free bursts and randomly gapped
    // stretches every few dozen words.
    burst = 1'b0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        burst = ($urandom_range(0, 9) < 3);
      end
      num = draw_operand();
      den = ($urandom_range(0, 99) < 6) ? '0 : draw_operand();
      if ($urandom_range(0, 199) == 0) begin
        num = MOST_NEG;
        den = MINUS_ONE;
      end
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      issue_word(num, den, gap);
    end
    start <= 1'b0;

    // Drain: wait for every expected word, bounded, then let the pipe
    // run empty so stray strobes are still caught.
    drain = 0;
    while (pending != 0 && drain < 4 * DRAIN_CYCLES) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending != 0) begin
      $display("%0d expected result words never arrived", pending);
    end
    $display("Sent %0d operand words (%0d with zero divisor, %0d overflow corners).",
             sent_words, zero_divisors, overflow_words);
    $display("Checked %0d result words, %0d errors.", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("PASS restoring_divider_core");
    end else begin
      $display("FAIL restoring_divider_core");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #200_000;
    $display("FAIL restoring_divider_core");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rdc_pkg.sv
hdl/rdc_prep.sv
hdl/rdc_cell.sv
hdl/rdc_post.sv
hdl/restoring_divider_core.sv
hdl/rdc_checker.sv
bench/rdc_div_checker.sv
bench/tb_top.sv
